@@ rtl/envelope_stage_sequencer_top_macros.svh @@
// ---------------------------------------------------------------------------
// Envelope stage sequencer assertion macros
// Shared forms for the concurrent checks of the sequencer modules.
// ---------------------------------------------------------------------------
`ifndef ENVELOPE_STAGE_SEQUENCER_TOP_MACROS_SVH
`define ENVELOPE_STAGE_SEQUENCER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset
`define ESS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ESS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/ess_pkg.sv @@
// ---------------------------------------------------------------------------
// Envelope stage sequencer package
// Result source codes shared by the stage logic and the top level.
// ---------------------------------------------------------------------------
package ess_pkg;

  // Where the downstream stage takes its output from
  typedef enum logic [1:0] {
    SRC_CURVE = 2'd0,
    SRC_LEVEL = 2'd1,
    SRC_INPUT = 2'd2
  } source_t;

endpackage

@@ rtl/ess_core.sv @@
// ---------------------------------------------------------------------------
// Envelope stage sequencer core
// Mode selection, stage phase and end-of-cycle timer; one sample a cycle while step_en is high.
// Results are combinational from the registered item and the stage state.
// ---------------------------------------------------------------------------
`include "envelope_stage_sequencer_top_macros.svh"

module ess_core #(
  parameter int PHASE_FRAC_BITS = 24,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step_en,
  input  logic [PHASE_FRAC_BITS:0]             eoc_step,
  input  logic                                 defer_gate,
  input  logic                                 trigger_gate,
  input  logic signed [SAMPLE_BITS-1:0]        envelope_in,
  input  logic signed [SAMPLE_BITS-1:0]        target_level,
  input  logic [PHASE_FRAC_BITS:0]             phase_step,
  output ess_pkg::source_t                     out_source,
  output logic signed [SAMPLE_BITS-1:0]        out_value,
  output logic [PHASE_FRAC_BITS:0]             curve_phase,
  output logic signed [SAMPLE_BITS-1:0]        curve_start,
  output logic                                 active,
  output logic                                 eoc
);

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam logic [PW-1:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [PW:0]   PHASE_ONE_W = {1'b0, PHASE_ONE};

  typedef enum logic [1:0] {
    MODE_DEFERRING   = 2'd0,
    MODE_TRACK_INPUT = 2'd1,
    MODE_GENERATING  = 2'd2,
    MODE_TRACK_LEVEL = 2'd3
  } mode_t;

  mode_t                        mode, mode_next, mode_sel;
  logic                         trigger_was_high, trigger_was_high_next;
  logic signed [SAMPLE_BITS-1:0] start_voltage, start_voltage_next;
  logic [PW-1:0]                stage_phase, stage_phase_next;
  logic                         eoc_flag, eoc_flag_next;
  logic [PW-1:0]                eoc_phase, eoc_phase_next;

  logic [PW-1:0] phase_base;
  logic [PW:0]   phase_sum;
  logic [PW-1:0] phase_sat;
  logic          eoc_start;
  logic [PW-1:0] eoc_base;
  logic          eoc_flag_base;
  logic [PW:0]   eoc_sum;

  // Pick the mode from the gates and the current mode
  always_comb begin
    mode_sel              = mode;
    trigger_was_high_next = trigger_was_high;
    start_voltage_next    = start_voltage;
    phase_base            = stage_phase;
    if (defer_gate) begin
      mode_sel = MODE_DEFERRING;
    end else if (mode == MODE_DEFERRING) begin
      trigger_was_high_next = 1'b0;
      mode_sel              = MODE_TRACK_INPUT;
    end else begin
      trigger_was_high_next = trigger_gate;
      if (trigger_gate && !trigger_was_high) begin
        start_voltage_next = envelope_in;
        phase_base         = '0;
        mode_sel           = MODE_GENERATING;
      end
    end
  end

  // Advance the stage phase, saturating at one
  assign phase_sum = {1'b0, phase_base} + {1'b0, phase_step};
  assign phase_sat = (phase_sum >= PHASE_ONE_W) ? PHASE_ONE : phase_sum[PW-1:0];

  // Build the result and detect completion
  always_comb begin
    mode_next        = mode_sel;
    stage_phase_next = stage_phase;
    eoc_start        = 1'b0;
    out_source       = ess_pkg::SRC_INPUT;
    out_value        = envelope_in;
    curve_phase      = '0;
    curve_start      = '0;
    case (mode_sel)
      MODE_GENERATING: begin
        stage_phase_next = phase_sat;
        out_source       = ess_pkg::SRC_CURVE;
        out_value        = '0;
        curve_phase      = phase_sat;
        curve_start      = start_voltage_next;
        if (phase_sat == PHASE_ONE) begin
          mode_next = MODE_TRACK_LEVEL;
          eoc_start = 1'b1;
        end
      end
      MODE_TRACK_LEVEL: begin
        out_source = ess_pkg::SRC_LEVEL;
        out_value  = target_level;
      end
      default: begin
        out_source = ess_pkg::SRC_INPUT;
        out_value  = envelope_in;
      end
    endcase
  end

  // Run the end-of-cycle timer; drop the flag when it expires
  assign eoc_base      = eoc_start ? '0 : eoc_phase;
  assign eoc_flag_base = eoc_start | eoc_flag;
  assign eoc_sum       = {1'b0, eoc_base} + {1'b0, eoc_step};

  always_comb begin
    eoc_phase_next = eoc_base;
    eoc_flag_next  = eoc_flag_base;
    if (eoc_base < PHASE_ONE) begin
      if (eoc_sum >= PHASE_ONE_W) begin
        eoc_phase_next = PHASE_ONE;
        eoc_flag_next  = 1'b0;
      end else begin
        eoc_phase_next = eoc_sum[PW-1:0];
      end
    end
  end

  assign active = (mode_next == MODE_DEFERRING) || (mode_next == MODE_GENERATING);
  assign eoc    = eoc_flag_next;

  // Hold state between samples, advance on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_TRACK_INPUT;
      trigger_was_high <= 1'b0;
      start_voltage    <= '0;
      stage_phase      <= '0;
      eoc_flag         <= 1'b0;
      eoc_phase        <= PHASE_ONE;
    end else if (step_en) begin
      mode             <= mode_next;
      trigger_was_high <= trigger_was_high_next;
      start_voltage    <= start_voltage_next;
      stage_phase      <= stage_phase_next;
      eoc_flag         <= eoc_flag_next;
      eoc_phase        <= eoc_phase_next;
    end
  end

  `ESS_ASSERT(a_stage_phase_bound, stage_phase <= PHASE_ONE, "stage phase above one")
  `ESS_ASSERT(a_eoc_phase_bound, eoc_phase <= PHASE_ONE, "eoc timer above one")
  `ESS_ASSERT_IMPL(a_eoc_flag_timer, eoc_flag, eoc_phase < PHASE_ONE, "eoc flag with timer expired")

endmodule

@@ rtl/envelope_stage_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// Envelope stage sequencer
// One envelope stage per audio sample: defer, trigger, phase and EOC pulse.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   cfg      | cfg_wr_en              | cfg_wr_data (eoc_step)
//   in       | in_valid / in_ready    | defer_gate .. phase_step
//   out      | out_valid / out_ready  | out_source .. eoc
//
// One sample per cycle sustained while out_ready stays high; each sample passes
// the input register, then the stage logic into the result register.
// The stage state carries from one sample to the next inside the core, so
// back-to-back samples see each other's updates with no bubble.
// Reset (synchronous) empties both registers and sets eoc_step to 381.
// A stalled output holds both stages; in_ready drops only when both are full.
// ---------------------------------------------------------------------------
`include "envelope_stage_sequencer_top_macros.svh"

module envelope_stage_sequencer_top #(
  parameter int PHASE_FRAC_BITS = 24,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [PHASE_FRAC_BITS:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          defer_gate,
  input  logic                          trigger_gate,
  input  logic signed [SAMPLE_BITS-1:0] envelope_in,
  input  logic signed [SAMPLE_BITS-1:0] target_level,
  input  logic [PHASE_FRAC_BITS:0]      phase_step,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ess_pkg::source_t              out_source,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic [PHASE_FRAC_BITS:0]      curve_phase,
  output logic signed [SAMPLE_BITS-1:0] curve_start,
  output logic                          active,
  output logic                          eoc
);

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam logic [PW-1:0] EOC_STEP_RESET = PW'(381);
  localparam logic [PW-1:0] PHASE_ONE = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

  logic [PW-1:0] eoc_step;

  logic                          item_valid;
  logic                          item_defer;
  logic                          item_trigger;
  logic signed [SAMPLE_BITS-1:0] item_envelope;
  logic signed [SAMPLE_BITS-1:0] item_level;
  logic [PW-1:0]                 item_step;

  logic out_free;
  logic item_adv;
  logic in_fire;

  ess_pkg::source_t              res_source;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic [PW-1:0]                 res_phase;
  logic signed [SAMPLE_BITS-1:0] res_start;
  logic                          res_active;
  logic                          res_eoc;

  // Advance when the next stage has room
  assign out_free = !out_valid || out_ready;
  assign item_adv = item_valid && out_free;
  assign in_ready = !item_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  // Write the end-of-cycle step register
  always_ff @(posedge clk) begin
    if (rst) begin
      eoc_step <= EOC_STEP_RESET;
    end else if (cfg_wr_en) begin
      eoc_step <= cfg_wr_data;
    end
  end

  // Capture an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_defer    <= defer_gate;
      item_trigger  <= trigger_gate;
      item_envelope <= envelope_in;
      item_level    <= target_level;
      item_step     <= phase_step;
    end
  end

  ess_core #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (item_adv),
    .eoc_step     (eoc_step),
    .defer_gate   (item_defer),
    .trigger_gate (item_trigger),
    .envelope_in  (item_envelope),
    .target_level (item_level),
    .phase_step   (item_step),
    .out_source   (res_source),
    .out_value    (res_value),
    .curve_phase  (res_phase),
    .curve_start  (res_start),
    .active       (res_active),
    .eoc          (res_eoc)
  );

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_adv) begin
      out_source  <= res_source;
      out_value   <= res_value;
      curve_phase <= res_phase;
      curve_start <= res_start;
      active      <= res_active;
      eoc         <= res_eoc;
    end
  end

  `ESS_ASSERT_IMPL(a_level_inactive, out_valid && (out_source == ess_pkg::SRC_LEVEL), !active, "level tracking reported active")
  `ESS_ASSERT_IMPL(a_curve_fields_clear, out_valid && (out_source != ess_pkg::SRC_CURVE), (curve_phase == '0) && (curve_start == '0), "curve fields set outside generation")
  `ESS_ASSERT_IMPL(a_partial_curve_active, out_valid && (out_source == ess_pkg::SRC_CURVE) && (curve_phase != PHASE_ONE), active, "unfinished curve not active")

endmodule
